### rtl/srle_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sprite run-length span decoder.
// Depends on nothing; every other file of the block refers to it by scoped names.

package srle_pkg;

    // Largest frame dimension honored; wider settings clip as this size.
    localparam int MAX_FRAME_DIM = 4096;

    localparam int DIM_W      = 13;
    localparam int ORIGIN_W   = 16;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 17;
    localparam int ADDR_W     = 24;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COL_W-1:0] COLUMN_MAX = '1;
    localparam logic [ROW_W-1:0] ROW_MAX    = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = 3'd4;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Key byte codes of the encoded stream.
    localparam logic [7:0] KEY_ROW_END = 8'd0;
    localparam logic [7:0] KEY_SKIP    = 8'd1;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       final_byte;
    } code_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  span_length;
        logic [7:0]        pixel_color;
    } span_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [ORIGIN_W-1:0] x_origin;
        logic [ORIGIN_W-1:0] y_origin;
        logic [ROW_W-1:0]    row_limit;
    } cfg_t;

    // Row bookkeeping that the decoder hands to the row base tracker.
    typedef struct packed {
        logic fire;
        logic restart;
        logic row_inc;
    } row_ctrl_t;

    // Clamp a frame dimension to the largest supported size.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (int'(v) > MAX_FRAME_DIM)
        begin
            r = DIM_W'(MAX_FRAME_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/srle_in_stage.sv
`timescale 1ns / 1ps
// Input register of the span decoder: holds one accepted code byte request.
// Depends on srle_pkg for the code item type.

module srle_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   code_valid,
    output logic                   code_stall,
    input  srle_pkg::code_item_t   code,
    input  logic                   cfg_write,
    input  logic                   fire,
    output logic                   s1_valid,
    output srle_pkg::code_item_t   s1_item
);

    logic                 valid_reg;
    logic                 valid_next;
    srle_pkg::code_item_t item_reg;
    logic                 take;

    // A configuration write holds off new bytes while cfg_write is high so the row
    // base register can pick up the new geometry first.
    assign code_stall = (valid_reg && !fire) || cfg_write;
    assign take       = code_valid && !code_stall;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                item_reg <= code;
            end
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

### rtl/srle_row_base.sv
`timescale 1ns / 1ps
// Row base address tracker: keeps (y_origin + row) * width modulo 2^24.
// Depends on srle_pkg for the configuration and row control types.

module srle_row_base (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srle_pkg::cfg_t                      cfg,
    input  logic [srle_pkg::ROW_W-1:0]          row_count,
    input  srle_pkg::row_ctrl_t                 ctrl,
    output logic [srle_pkg::ADDR_W-1:0]         row_base
);

    localparam int PROD_W = srle_pkg::COL_W + srle_pkg::DIM_W;

    logic [srle_pkg::ADDR_W-1:0] base_reg;
    logic [srle_pkg::ADDR_W-1:0] base_next;
    logic [srle_pkg::DIM_W-1:0]  fw;
    logic [srle_pkg::ROW_W-1:0]  mul_row;
    logic [srle_pkg::COL_W-1:0]  y_sum;
    logic [PROD_W-1:0]           prod;

    assign fw      = srle_pkg::eff_dim(cfg.frame_width);
    assign mul_row = ctrl.restart ? '0 : row_count;
    assign y_sum   = srle_pkg::COL_W'(cfg.y_origin) + srle_pkg::COL_W'(mul_row);
    assign prod    = PROD_W'(y_sum) * PROD_W'(fw);

    // A non-final byte that advances the row steps the base by one width;
    // other ones hold it; else it is recomputed, following config writes.
    always_comb
    begin
        if (ctrl.fire && !ctrl.restart)
        begin
            if (ctrl.row_inc)
            begin
                base_next = base_reg + srle_pkg::ADDR_W'(fw);
            end
            else
            begin
                base_next = base_reg;
            end
        end
        else
        begin
            base_next = prod[srle_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    assign row_base = base_reg;

endmodule

### rtl/srle_core.sv
`timescale 1ns / 1ps
// Decode stage and result register: walks the key/skip/literal/run phases,
// clips spans to the frame and registers one span request. Depends on srle_pkg.

module srle_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srle_pkg::cfg_t                      cfg,
    input  logic                                s1_valid,
    input  srle_pkg::code_item_t                s1_item,
    input  logic [srle_pkg::ADDR_W-1:0]         row_base,
    output logic                                fire,
    output srle_pkg::row_ctrl_t                 row_ctrl,
    output logic [srle_pkg::ROW_W-1:0]          row_count,
    output logic                                span_valid,
    input  logic                                span_stall,
    output srle_pkg::span_item_t                span
);

    typedef enum logic [1:0] {
        PH_KEY,
        PH_SKIP,
        PH_LIT,
        PH_RUN
    } phase_t;

    localparam int FX_W = srle_pkg::COL_W + 1;

    phase_t                         phase_reg,   phase_next;
    logic [srle_pkg::ROW_W-1:0]     row_reg,     row_next;
    logic [srle_pkg::COL_W-1:0]     column_reg,  column_next;
    logic [srle_pkg::LEN_W-1:0]     pending_reg, pending_next;
    logic                           out_valid_reg, out_valid_next;
    srle_pkg::span_item_t           out_reg,     out_next;

    logic                           active;
    logic                           row_inc;
    logic                           emit;
    logic [7:0]                     b;
    logic [srle_pkg::DIM_W-1:0]     fw;
    logic [srle_pkg::DIM_W-1:0]     fh;
    logic [srle_pkg::COL_W-1:0]     fy;
    logic [FX_W-1:0]                fx;
    logic                           on_frame;
    logic [srle_pkg::DIM_W-1:0]     room;
    logic [srle_pkg::LEN_W-1:0]     req_len;
    logic [srle_pkg::LEN_W-1:0]     clip_len;
    logic [7:0]                     col_step;
    logic [FX_W-1:0]                col_sum;
    logic [srle_pkg::COL_W-1:0]     col_sat;

    assign fire   = s1_valid && (!out_valid_reg || !span_stall);
    assign b      = s1_item.code_byte;
    assign active = row_reg < cfg.row_limit;

    assign fw       = srle_pkg::eff_dim(cfg.frame_width);
    assign fh       = srle_pkg::eff_dim(cfg.frame_height);
    assign fy       = srle_pkg::COL_W'(cfg.y_origin) + srle_pkg::COL_W'(row_reg);
    assign fx       = FX_W'(cfg.x_origin) + FX_W'(column_reg);
    assign on_frame = (fy < srle_pkg::COL_W'(fh)) && (fx < FX_W'(fw));
    assign room     = fw - fx[srle_pkg::DIM_W-1:0];

    assign req_len  = (phase_reg == PH_LIT) ? srle_pkg::LEN_W'(1) : pending_reg;
    assign clip_len = (srle_pkg::DIM_W'(req_len) > room) ?
                      room[srle_pkg::LEN_W-1:0] : req_len;

    always_comb
    begin
        case (phase_reg)
            PH_SKIP: col_step = b;
            PH_LIT:  col_step = 8'd1;
            PH_RUN:  col_step = 8'(pending_reg);
            default: col_step = 8'd0;
        endcase
    end

    assign col_sum = FX_W'(column_reg) + FX_W'(col_step);
    assign col_sat = (col_sum > FX_W'(srle_pkg::COLUMN_MAX)) ?
                     srle_pkg::COLUMN_MAX : col_sum[srle_pkg::COL_W-1:0];

    assign row_inc = fire && active && (phase_reg == PH_KEY)
                     && (b == srle_pkg::KEY_ROW_END)
                     && (row_reg != srle_pkg::ROW_MAX);

    always_comb
    begin
        phase_next   = phase_reg;
        row_next     = row_reg;
        column_next  = column_reg;
        pending_next = pending_reg;
        emit         = 1'b0;

        if (fire && active)
        begin
            case (phase_reg)
                PH_KEY:
                begin
                    if (b == srle_pkg::KEY_ROW_END)
                    begin
                        if (row_inc)
                        begin
                            row_next = row_reg + srle_pkg::ROW_W'(1);
                        end
                        column_next = '0;
                    end
                    else if (b == srle_pkg::KEY_SKIP)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        pending_next = b[7:1];
                        phase_next   = b[0] ? PH_LIT : PH_RUN;
                    end
                end
                PH_SKIP:
                begin
                    column_next = col_sat;
                    phase_next  = PH_KEY;
                end
                PH_LIT:
                begin
                    emit        = on_frame;
                    column_next = col_sat;
                    if (pending_reg <= srle_pkg::LEN_W'(1))
                    begin
                        pending_next = '0;
                        phase_next   = PH_KEY;
                    end
                    else
                    begin
                        pending_next = pending_reg - srle_pkg::LEN_W'(1);
                    end
                end
                default:
                begin
                    emit         = on_frame;
                    column_next  = col_sat;
                    pending_next = '0;
                    phase_next   = PH_KEY;
                end
            endcase
        end

        // The last byte of a sub-image sends the decoder back to its start.
        if (fire && s1_item.final_byte)
        begin
            phase_next   = PH_KEY;
            row_next     = '0;
            column_next  = '0;
            pending_next = '0;
        end
    end

    always_comb
    begin
        out_next.start_address = row_base + srle_pkg::ADDR_W'(fx);
        out_next.span_length   = clip_len;
        out_next.pixel_color   = b;
        out_valid_next         = fire ? emit : (out_valid_reg && span_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEY;
            row_reg       <= '0;
            column_reg    <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            column_reg    <= column_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            if (fire && emit)
            begin
                out_reg <= out_next;
            end
        end
    end

    assign row_ctrl.fire    = fire;
    assign row_ctrl.restart = fire && s1_item.final_byte;
    assign row_ctrl.row_inc = row_inc;
    assign row_count        = row_reg;
    assign span_valid       = out_valid_reg;
    assign span             = out_reg;

    // Literal and run phases always have bytes or pixels still owed.
    a_pending_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT || phase_reg == PH_RUN) |-> (pending_reg != '0))
        else $error("literal or run phase with nothing pending");

    // A span never carries zero pixels.
    a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.span_length != '0))
        else $error("empty span request");

    // The final byte of a sub-image leaves the decoder at its start.
    a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_item.final_byte) |=>
        (phase_reg == PH_KEY && row_reg == '0 && column_reg == '0))
        else $error("decoder not restarted after final byte");

endmodule

### rtl/sprite_rle_span_decoder.sv
`timescale 1ns / 1ps
// Top level of the sprite run-length span decoder: configuration registers and
// the input, decode and row base stages. Depends on srle_pkg and the srle_* modules.
//
// Usage:
//   The code channel (code_valid, code_stall, code) takes one byte of the
//   run-length stream per request; code.final_byte marks the last byte of a
//   sub-image, after which the decoder returns to row zero, column zero.
//   The span channel (span_valid, span_stall, span) delivers at most one
//   clipped frame-buffer span request per byte.
//   A byte accepted into the input register is decoded into the result
//   register, from which its span can be taken. Throughput is one byte per
//   cycle while span_stall and cfg_write stay low; each byte's work is one
//   pass through the decode logic between the input register and the result
//   register, with the row base address kept in a register of its own so no
//   multiplier sits in that path.
//   A configuration write (cfg_write, cfg_index, cfg_data) raises code_stall
//   in its own cycle; writes are meant for idle periods between streams.
//   When the receiver holds span_stall, the result register keeps its span,
//   the byte waiting in the input register holds, and code_stall rises.
//   Reset loads the register defaults (width 640, height 480, origins and
//   row limit zero) and puts the decoder at the start of a sub-image; there
//   is no clearing pass. With a row limit of zero every byte is dropped.

module sprite_rle_span_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                code_valid,
    output logic                                code_stall,
    input  srle_pkg::code_item_t                code,
    output logic                                span_valid,
    input  logic                                span_stall,
    output srle_pkg::span_item_t                span,
    input  logic                                cfg_write,
    input  logic [srle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srle_pkg::CFG_DATA_W-1:0]     cfg_data
);

    srle_pkg::cfg_t              cfg_reg;
    srle_pkg::code_item_t        s1_item;
    srle_pkg::row_ctrl_t         row_ctrl;
    logic                        s1_valid;
    logic                        fire;
    logic [srle_pkg::ROW_W-1:0]  row_count;
    logic [srle_pkg::ADDR_W-1:0] row_base;

    // Configuration registers. Writes to an index past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= srle_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height <= srle_pkg::FRAME_HEIGHT_RST;
            cfg_reg.x_origin     <= '0;
            cfg_reg.y_origin     <= '0;
            cfg_reg.row_limit    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                srle_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width  <= cfg_data[srle_pkg::DIM_W-1:0];
                srle_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[srle_pkg::DIM_W-1:0];
                srle_pkg::REG_X_ORIGIN:
                    cfg_reg.x_origin     <= cfg_data;
                srle_pkg::REG_Y_ORIGIN:
                    cfg_reg.y_origin     <= cfg_data;
                srle_pkg::REG_ROW_LIMIT:
                    cfg_reg.row_limit    <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register; it frees up whenever the decode stage fires.
    srle_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code),
        .cfg_write  (cfg_write),
        .fire       (fire),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    // Decoder state, clipping and the span result register.
    srle_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .row_base   (row_base),
        .fire       (fire),
        .row_ctrl   (row_ctrl),
        .row_count  (row_count),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .span       (span)
    );

    // Frame address of column zero of the current row.
    srle_row_base u_row_base (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .row_count (row_count),
        .ctrl      (row_ctrl),
        .row_base  (row_base)
    );

endmodule

### sim/sprite_rle_span_decoder_checker.sv
`timescale 1ns / 1ps
// Span checker that predicts and compares the decoder's span requests.
// Depends on srle_pkg.

module sprite_rle_span_decoder_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            code_valid,
    input  logic                            code_stall,
    input  srle_pkg::code_item_t            code,
    input  logic                            span_valid,
    input  logic                            span_stall,
    input  srle_pkg::span_item_t            span,
    input  logic                            cfg_write,
    input  logic [srle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srle_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              spans_waiting
);

    typedef enum logic [1:0] {WANT_KEY, WANT_SKIP, WANT_LITERAL, WANT_RUN_COLOR} parse_state_t;

    // Shadow copy of the configuration registers.
    logic [srle_pkg::DIM_W-1:0]    width_reg;
    logic [srle_pkg::DIM_W-1:0]    height_reg;
    logic [srle_pkg::ORIGIN_W-1:0] x_org;
    logic [srle_pkg::ORIGIN_W-1:0] y_org;
    logic [srle_pkg::ROW_W-1:0]    row_stop;

    // Parser position within the encoded stream.
    parse_state_t                  parse_state;
    logic [srle_pkg::ROW_W-1:0]    row_num;
    logic [srle_pkg::COL_W-1:0]    col_num;
    logic [srle_pkg::LEN_W-1:0]    count_left;

    srle_pkg::span_item_t          spans_due[$];

    function automatic int unsigned clip_dim(input logic [srle_pkg::DIM_W-1:0] v);
        return (int'(v) > srle_pkg::MAX_FRAME_DIM) ? srle_pkg::MAX_FRAME_DIM : int'(v);
    endfunction

    function automatic logic [srle_pkg::COL_W-1:0] col_advance(
        input logic [srle_pkg::COL_W-1:0] c,
        input int unsigned n);
        int unsigned s;
        s = c + n;
        return (s > srle_pkg::COLUMN_MAX) ? srle_pkg::COLUMN_MAX : srle_pkg::COL_W'(s);
    endfunction

    // Advances the parser by one stream byte and works out the span it paints, if any.
    task automatic decode_byte(input srle_pkg::code_item_t req, output bit produced,
                               output srle_pkg::span_item_t want);
        int unsigned fw;
        int unsigned fh;
        int unsigned fy;
        int unsigned fx;
        int unsigned room;
        int unsigned len;
        int unsigned base;
        bit          paint;
        fw = clip_dim(width_reg);
        fh = clip_dim(height_reg);
        fy = y_org + row_num;
        fx = x_org + col_num;
        base = (fy * fw) & 32'h00FF_FFFF;
        paint = 1'b0;
        len = 0;
        produced = 1'b0;
        want = '0;
        if (row_num < row_stop)
        begin
            case (parse_state)
                WANT_KEY:
                begin
                    if (req.code_byte == srle_pkg::KEY_ROW_END)
                    begin
                        if (row_num != srle_pkg::ROW_MAX)
                        begin
                            row_num = row_num + 1'b1;
                        end
                        col_num = '0;
                    end
                    else if (req.code_byte == srle_pkg::KEY_SKIP)
                    begin
                        parse_state = WANT_SKIP;
                    end
                    else
                    begin
                        count_left = req.code_byte[7:1];
                        parse_state = req.code_byte[0] ? WANT_LITERAL : WANT_RUN_COLOR;
                    end
                end
                WANT_SKIP:
                begin
                    col_num = col_advance(col_num, req.code_byte);
                    parse_state = WANT_KEY;
                end
                WANT_LITERAL:
                begin
                    paint = 1'b1;
                    len = 1;
                    col_num = col_advance(col_num, 1);
                    if (count_left != '0)
                    begin
                        count_left = count_left - 1'b1;
                    end
                    if (count_left == '0)
                    begin
                        parse_state = WANT_KEY;
                    end
                end
                default:
                begin
                    paint = 1'b1;
                    len = count_left;
                    col_num = col_advance(col_num, count_left);
                    count_left = '0;
                    parse_state = WANT_KEY;
                end
            endcase
        end
        if (paint && fy < fh && fx < fw)
        begin
            room = fw - fx;
            produced = 1'b1;
            want.start_address = srle_pkg::ADDR_W'(base + fx);
            want.span_length = srle_pkg::LEN_W'((len > room) ? room : len);
            want.pixel_color = req.code_byte;
        end
        if (req.final_byte)
        begin
            parse_state = WANT_KEY;
            row_num = '0;
            col_num = '0;
            count_left = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        srle_pkg::span_item_t want;
        bit                   produced;
        if (!rst_n)
        begin
            width_reg = srle_pkg::FRAME_WIDTH_RST;
            height_reg = srle_pkg::FRAME_HEIGHT_RST;
            x_org = '0;
            y_org = '0;
            row_stop = '0;
            parse_state = WANT_KEY;
            row_num = '0;
            col_num = '0;
            count_left = '0;
            spans_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (span_valid && !span_stall)
            begin
                if (spans_due.size() == 0)
                begin
                    $error("span request with none pending: address %0d, length %0d",
                           span.start_address, span.span_length);
                    mismatches++;
                end
                else
                begin
                    want = spans_due.pop_front();
                    if (span.start_address !== want.start_address)
                    begin
                        $error("start_address: expected %0d, got %0d",
                               want.start_address, span.start_address);
                        mismatches++;
                    end
                    if (span.span_length !== want.span_length)
                    begin
                        $error("span_length: expected %0d, got %0d",
                               want.span_length, span.span_length);
                        mismatches++;
                    end
                    if (span.pixel_color !== want.pixel_color)
                    begin
                        $error("pixel_color: expected %0d, got %0d",
                               want.pixel_color, span.pixel_color);
                        mismatches++;
                    end
                end
            end
            if (code_valid && !code_stall)
            begin
                decode_byte(code, produced, want);
                if (produced)
                begin
                    spans_due.insert(spans_due.size(), want);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    srle_pkg::REG_FRAME_WIDTH:
                        width_reg = cfg_data[srle_pkg::DIM_W-1:0];
                    srle_pkg::REG_FRAME_HEIGHT:
                        height_reg = cfg_data[srle_pkg::DIM_W-1:0];
                    srle_pkg::REG_X_ORIGIN:
                        x_org = cfg_data[srle_pkg::ORIGIN_W-1:0];
                    srle_pkg::REG_Y_ORIGIN:
                        y_org = cfg_data[srle_pkg::ORIGIN_W-1:0];
                    srle_pkg::REG_ROW_LIMIT:
                        row_stop = cfg_data[srle_pkg::ROW_W-1:0];
                    default:          ;
                endcase
            end
        end
        spans_waiting = spans_due.size();
    end

endmodule

### sim/sprite_rle_span_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sprite run-length span decoder: clock, reset, stream and
// configuration stimulus, and the verdict. Depends on srle_pkg and the span checker file.

module sprite_rle_span_decoder_tb;

    // Generous ceiling; a correct run with all the stalls below needs a small fraction.
    localparam int CYCLE_LIMIT    = 200000;
    // Random stream bytes to queue, not counting the phases that drop every byte.
    localparam int LIVE_BYTES     = 450;
    // Length of the receiver's long hold-off, long enough to back up the whole pipe.
    localparam int HOLDOFF_CYCLES = 160;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            code_valid = 1'b0;
    logic                            code_stall;
    srle_pkg::code_item_t            code = '0;
    logic                            span_valid;
    logic                            span_stall = 1'b0;
    srle_pkg::span_item_t            span;
    logic                            cfg_write = 1'b0;
    logic [srle_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [srle_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                              mismatches;
    int                              spans_waiting;

    // Stream bytes waiting to be offered; the head is the one on the code channel.
    srle_pkg::code_item_t            bytes_queued[$];
    int                              burst_left;
    int                              gap_left;
    int                              stall_left;
    int                              free_left;
    int                              hold_left;
    int                              holdoff_asked = 0;
    int                              holdoff_served = 0;
    int                              cycle_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sprite_rle_span_decoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .span       (span),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    sprite_rle_span_decoder_checker span_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .code          (code),
        .span_valid    (span_valid),
        .span_stall    (span_stall),
        .span          (span),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .spans_waiting (spans_waiting)
    );

    // Sender. Requests go out in bursts of random length separated by random gaps;
    // a gap of zero joins two bursts, so long unbroken stretches happen as well.
    // A stalled request is held with its payload untouched.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (code_valid && !code_stall)
            begin
                void'(bytes_queued.pop_front());
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (code_valid && code_stall)
            begin
                // The decoder has not taken the request yet; keep offering it.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                code_valid <= 1'b0;
            end
            else if (bytes_queued.size() > 0)
            begin
                code_valid <= 1'b1;
                code <= bytes_queued[0];
            end
            else
            begin
                code_valid <= 1'b0;
            end
        end
    end

    // Receiver. Short stall and free segments alternate, with occasional long free
    // stretches. When the stimulus asks for it, the receiver holds off for a long
    // stretch set by HOLDOFF_CYCLES while the sender keeps offering, which backs the decoder
    // up until it stalls its own input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_stall <= 1'b0;
            stall_left = 0;
            free_left = 0;
            hold_left = 0;
            holdoff_served = 0;
        end
        else
        begin
            if (holdoff_served != holdoff_asked)
            begin
                holdoff_served = holdoff_asked;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                span_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                span_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                span_stall <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    stall_left = 0;
                    free_left = $urandom_range(20, 60);
                end
                else
                begin
                    stall_left = $urandom_range(0, 4);
                    free_left = $urandom_range(1, 6);
                end
                span_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run that hangs waiting for a span request ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Pushes are made at the falling edge so they never race the sender's clock edge.
    task automatic push_byte(input logic [7:0] b, input logic last);
        srle_pkg::code_item_t item;
        item.code_byte = b;
        item.final_byte = last;
        bytes_queued.insert(bytes_queued.size(), item);
    endtask

    task automatic write_reg(input logic [srle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [srle_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Loads all five registers; only called while the decoder is idle.
    task automatic set_frame(input int w, input int h, input int xo, input int yo,
                             input int lim);
        write_reg(srle_pkg::REG_FRAME_WIDTH, srle_pkg::CFG_DATA_W'(w));
        write_reg(srle_pkg::REG_FRAME_HEIGHT, srle_pkg::CFG_DATA_W'(h));
        write_reg(srle_pkg::REG_X_ORIGIN, srle_pkg::CFG_DATA_W'(xo));
        write_reg(srle_pkg::REG_Y_ORIGIN, srle_pkg::CFG_DATA_W'(yo));
        write_reg(srle_pkg::REG_ROW_LIMIT, srle_pkg::CFG_DATA_W'(lim));
        @(negedge clk);
    endtask

    // Waits until every queued byte has been taken and every predicted span has
    // arrived, then lets a last byte that was still in flight without a span of
    // its own settle (it may still sit in the input register).
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (bytes_queued.size() != 0 || code_valid || spans_waiting != 0);
        repeat (4) @(negedge clk);
    endtask

    // Queues one command of the encoded stream: mostly well-formed rows, skips,
    // literal groups and runs with random contents, plus some raw noise. Any byte
    // may end the sub-image, which also cuts literal groups short.
    task automatic queue_command(inout int pushed);
        int pick;
        int cnt;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            push_byte(srle_pkg::KEY_ROW_END, $urandom_range(0, 47) == 0);
            pushed += 1;
        end
        else if (pick < 25)
        begin
            push_byte(srle_pkg::KEY_SKIP, $urandom_range(0, 47) == 0);
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 47) == 0);
            pushed += 2;
        end
        else if (pick < 55)
        begin
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
            push_byte({7'(cnt), 1'b1}, $urandom_range(0, 47) == 0);
            repeat (cnt)
            begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 47) == 0);
            end
            pushed += cnt + 1;
        end
        else if (pick < 85)
        begin
            cnt = $urandom_range(1, 127);
            push_byte({7'(cnt), 1'b0}, $urandom_range(0, 47) == 0);
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 47) == 0);
            pushed += 2;
        end
        else
        begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 47) == 0);
            pushed += 1;
        end
    endtask

    initial
    begin : stimulus
        int phase_no;
        int live_count;
        int pushed;
        int budget;
        bit drops_all;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Out of reset the row limit is zero, so a literal group is dropped whole.
        push_byte(8'd3, 1'b0);
        push_byte(8'h11, 1'b0);
        drain();

        // Directed stream on a tiny frame: a literal, a skip, a run cut at the right
        // edge, a literal group, writes past the right edge and below the bottom edge,
        // the row limit taking hold, and sub-images that end on a run key, a skip key
        // and a literal.
        set_frame(16, 5, 2, 1, 5);
        push_byte(8'd3, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(srle_pkg::KEY_SKIP, 1'b0);
        push_byte(8'd10, 1'b0);
        push_byte(8'd254, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(srle_pkg::KEY_ROW_END, 1'b0);
        push_byte(8'd5, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(srle_pkg::KEY_SKIP, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd3, 1'b0);
        push_byte(8'd7, 1'b0);
        push_byte(srle_pkg::KEY_ROW_END, 1'b0);
        push_byte(srle_pkg::KEY_ROW_END, 1'b0);
        push_byte(srle_pkg::KEY_ROW_END, 1'b0);
        push_byte(8'd3, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(srle_pkg::KEY_ROW_END, 1'b0);
        push_byte(8'd4, 1'b0);
        push_byte(8'd2, 1'b1);
        push_byte(8'd4, 1'b1);
        push_byte(srle_pkg::KEY_SKIP, 1'b1);
        push_byte(8'd3, 1'b0);
        push_byte(8'h42, 1'b1);
        drain();

        // Back pressure: the receiver holds off for a long stretch while a group of
        // forty literals streams in, so the result and input registers both fill
        // and the decoder stalls its input until the receiver lets go.
        set_frame(640, 480, 0, 0, 100);
        holdoff_asked++;
        push_byte(8'd81, 1'b0);
        repeat (39)
        begin
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        drain();

        // Random part. Each phase picks a frame setting, from tiny frames to the
        // extremes of every register, then streams random commands. The decoder's
        // state carries over between phases, so a stream may stop mid-command and
        // then meet a lower row limit.
        phase_no = 0;
        live_count = 0;
        while (live_count < LIVE_BYTES)
        begin
            drops_all = 1'b0;
            case (phase_no % 8)
                0: set_frame($urandom_range(1, 40), $urandom_range(1, 12),
                             $urandom_range(0, 20), $urandom_range(0, 6),
                             $urandom_range(1, 16));
                1: set_frame(srle_pkg::MAX_FRAME_DIM, srle_pkg::MAX_FRAME_DIM,
                             $urandom_range(3900, 4095), $urandom_range(4080, 4095), 65535);
                // Register values above the largest frame size clip as that size.
                2: set_frame(8191, $urandom_range(4097, 8191), 0, 0, $urandom_range(1, 40));
                3: set_frame(1, 1, 0, 0, $urandom_range(1, 4));
                4: set_frame($urandom_range(1, 300), $urandom_range(1, 300),
                             $urandom_range(0, 200), $urandom_range(0, 100),
                             $urandom_range(1, 200));
                5: set_frame($urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
                // A zero dimension clips every span away.
                6:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        set_frame(0, $urandom_range(1, 50), 0, 0, 30);
                    end
                    else
                    begin
                        set_frame($urandom_range(1, 50), 0, 0, 0, 30);
                    end
                end
                default:
                begin
                    set_frame(640, 480, 0, 0, 0);
                    drops_all = 1'b1;
                end
            endcase
            if (phase_no == 1 || phase_no == 4)
            begin
                holdoff_asked++;
            end
            budget = drops_all ? 12 : 50;
            pushed = 0;
            while (pushed < budget)
            begin
                queue_command(pushed);
            end
            if (!drops_all)
            begin
                live_count += pushed;
            end
            drain();
            phase_no++;
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0 && spans_waiting == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/srle_pkg.sv
rtl/srle_in_stage.sv
rtl/srle_row_base.sv
rtl/srle_core.sv
rtl/sprite_rle_span_decoder.sv
sim/sprite_rle_span_decoder_checker.sv
sim/sprite_rle_span_decoder_tb.sv
